### design/fcms_pkg.sv
// fcms_pkg: types, address decode constants and the carrier table shared by
// the FM mute/shadow front end and its checker. No dependencies.
package fcms_pkg;

    // Channel and operator geometry
    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int OPS      = 4;
    localparam int OP_W     = 2;
    localparam int LVL_W    = 7;
    localparam int ALG_W    = 3;
    localparam int LVL_AW   = CH_W + OP_W;

    // Function codes
    localparam logic FUNC_REG_WRITE = 1'b0;
    localparam logic FUNC_MUTE      = 1'b1;

    // Address decode
    localparam logic [2:0] LVL_PAGE   = 3'b011;    // 0x60-0x7F
    localparam logic [4:0] ALG_PAGE   = 5'b00100;  // 0x20-0x27
    localparam logic [LVL_W-1:0] LVL_MAX = 7'h7F;

    typedef struct packed {
        logic       func;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic       mute_on;
    } t_in_item;

    typedef struct packed {
        logic [7:0] chip_addr;
        logic [7:0] chip_data;
        logic       last;
    } t_out_item;

    // Carrier operators per algorithm; bit k selects operator k
    function automatic logic [OPS-1:0] carrier_mask(input logic [ALG_W-1:0] alg);
        logic [OPS-1:0] m;
        unique case (alg)
            3'd0, 3'd1, 3'd2, 3'd3: m = 4'h8;
            3'd4:                   m = 4'hC;
            3'd5, 3'd6:             m = 4'hE;
            default:                m = 4'hF;
        endcase
        return m;
    endfunction

endpackage

### design/fm_chip_mute_shadow.sv
// fm_chip_mute_shadow: shadowing front end for an FM synthesizer register
// port. Depends on fcms_pkg and fcms_ram.
//
// Usage:
//   An input transaction is taken when start is high and busy is low. A
//   register write (func 0) is forwarded to the chip as one write, shown on
//   o_result with o_strobe in the cycle after it is taken, last set. It also
//   updates the total-level shadow (0x60-0x7F) or algorithm shadow
//   (0x20-0x27). While busy is low, register writes are taken back to
//   back, one per cycle. A mute command (func 1) raises busy and walks
//   channels 0..7. For each channel it reads the algorithm shadow, then
//   for each carrier operator reads the level shadow and emits one
//   total-level write (0x7F when muting, the shadowed level when
//   restoring), so a command gives between 8 and 32 writes. Each shadow
//   RAM has a single registered read port, so each read has a request
//   state ahead of the state that uses its data. Only the final write
//   carries last. Results cannot be stalled: each is valid for exactly
//   one cycle. Reset clears the shadow valid bits, so levels read 0x7F
//   and algorithms read 0 until written; there is no clearing pass.
module fm_chip_mute_shadow (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fcms_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output fcms_pkg::t_out_item o_result
);
    import fcms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALG_REQ,
        S_ALG_USE,
        S_LVL_REQ,
        S_LVL_USE
    } t_state;

    t_state           r_state;
    logic [CH_W-1:0]  r_ch;
    logic [OP_W-1:0]  r_k;
    logic [OPS-1:0]   r_mask;
    logic             r_mute;
    logic             r_strobe;
    t_out_item        r_result;

    logic [(1 << LVL_AW)-1:0] r_lvl_vld;
    logic [CHANNELS-1:0] r_alg_vld;
    logic             r_lvl_rd_vld;
    logic             r_alg_rd_vld;

    logic             accept;
    logic             reg_wr;
    logic             lvl_we;
    logic             alg_we;
    logic [LVL_AW-1:0] lvl_raddr;
    logic [LVL_W-1:0] lvl_rdata;
    logic [ALG_W-1:0] alg_rdata;
    logic [LVL_W-1:0] lvl_val;
    logic [ALG_W-1:0] alg_val;
    logic             n_last;

    // Decode incoming transaction
    assign accept = start && !busy;
    assign reg_wr = accept && (i_item.func == FUNC_REG_WRITE);
    assign lvl_we = reg_wr && (i_item.reg_addr[7:5] == LVL_PAGE);
    assign alg_we = reg_wr && (i_item.reg_addr[7:3] == ALG_PAGE);

    assign lvl_raddr = {r_k, r_ch};

    fcms_ram #(
        .WIDTH (LVL_W),
        .DEPTH (32)
    ) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (i_item.reg_addr[LVL_AW-1:0]),
        .i_wdata (i_item.reg_data[LVL_W-1:0]),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    fcms_ram #(
        .WIDTH (ALG_W),
        .DEPTH (CHANNELS)
    ) u_alg_ram (
        .i_clk   (i_clk),
        .i_we    (alg_we),
        .i_waddr (i_item.reg_addr[CH_W-1:0]),
        .i_wdata (i_item.reg_data[ALG_W-1:0]),
        .i_raddr (r_ch),
        .o_rdata (alg_rdata)
    );

    // Unwritten entries read as their reset value
    assign lvl_val = r_lvl_rd_vld ? lvl_rdata : LVL_MAX;
    assign alg_val = r_alg_rd_vld ? alg_rdata : '0;
    assign n_last  = (r_ch == CH_W'(CHANNELS - 1)) && (r_k == OP_W'(OPS - 1));

    // Track written entries; sample valid alongside each RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld <= '0;
            r_alg_vld <= '0;
        end else begin
            if (lvl_we) begin
                r_lvl_vld[i_item.reg_addr[LVL_AW-1:0]] <= 1'b1;
            end
            if (alg_we) begin
                r_alg_vld[i_item.reg_addr[CH_W-1:0]] <= 1'b1;
            end
        end
        r_lvl_rd_vld <= r_lvl_vld[lvl_raddr];
        r_alg_rd_vld <= r_alg_vld[r_ch];
    end

    // Sequencer: forward register writes, walk carriers on a mute command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_ch     <= '0;
            r_k      <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (reg_wr) begin
                        r_strobe           <= 1'b1;
                        r_result.chip_addr <= i_item.reg_addr;
                        r_result.chip_data <= i_item.reg_data;
                        r_result.last      <= 1'b1;
                    end else if (accept) begin
                        r_mute  <= i_item.mute_on;
                        r_ch    <= '0;
                        r_state <= S_ALG_REQ;
                    end
                end
                S_ALG_REQ: begin
                    r_state <= S_ALG_USE;
                end
                S_ALG_USE: begin
                    r_mask  <= carrier_mask(alg_val);
                    r_k     <= '0;
                    r_state <= S_LVL_REQ;
                end
                S_LVL_REQ: begin
                    // operator 3 is a carrier in every algorithm
                    if (r_mask[r_k]) begin
                        r_state <= S_LVL_USE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_LVL_USE: begin
                    r_strobe           <= 1'b1;
                    r_result.chip_addr <= {LVL_PAGE, r_k, r_ch};
                    r_result.chip_data <= {1'b0, (r_mute ? LVL_MAX : lvl_val)};
                    r_result.last      <= n_last;
                    if (r_k == OP_W'(OPS - 1)) begin
                        if (r_ch == CH_W'(CHANNELS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_ALG_REQ;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LVL_REQ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### design/fcms_ram.sv
// fcms_ram: generic single-write, single-read synchronous RAM with a
// registered read. No package dependencies.
module fcms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/fcms_checker.sv
// fcms_checker: port-level assertions for fm_chip_mute_shadow, bound to the
// top level below. Depends on fcms_pkg.
module fcms_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input fcms_pkg::t_in_item  i_item,
    input logic                o_strobe,
    input fcms_pkg::t_out_item o_result
);
    import fcms_pkg::*;

    // A register write comes out next cycle, unchanged and marked last
    a_reg_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == FUNC_REG_WRITE) |=>
            (o_strobe && o_result.last &&
             o_result.chip_addr == $past(i_item.reg_addr) &&
             o_result.chip_data == $past(i_item.reg_data)))
        else $error("register write not forwarded");

    // A mute command holds off further transactions
    a_mute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == FUNC_MUTE) |=> busy)
        else $error("mute command did not raise busy");

    // Non-final writes only come from a mute run, which is still busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("non-final write while idle");

    // Mute run writes target total-level registers only
    a_mid_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |->
            (o_result.chip_addr[7:5] == LVL_PAGE && !o_result.chip_data[7]))
        else $error("mute write outside total-level range");

endmodule

bind fm_chip_mute_shadow fcms_checker u_fcms_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
